>>> rtl/kvlp_pkg.sv
package kvlp_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int MAG_W   = 32;
    // Wide enough for mag * 16 + 15 with mag at most 2^31.
    localparam int STEP_W  = 36;

    localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_LOW_X = 8'h78;
    localparam logic [BYTE_W-1:0] CHAR_UP_X  = 8'h58;

    localparam logic [MAG_W-1:0]   MAG_CAP   = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    // Digit code for a byte that is no hex digit.
    localparam logic [4:0] DIGIT_NONE = 5'd16;
    localparam logic [4:0] DEC_BASE   = 5'd10;

    // Value scan: still in leading blanks and sign, or among the digits.
    typedef enum logic
    {
        PH_LEAD,
        PH_DIGITS
    } scan_phase_t;

    // Hex scan, including the optional 0x prefix.
    typedef enum logic [2:0]
    {
        HX_FIRST,
        HX_ZERO,
        HX_PREFIX,
        HX_RUN,
        HX_STOP
    } hex_state_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_WAIT,
        BK_SEND
    } back_state_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_x(input logic [BYTE_W-1:0] c);
        return (c == CHAR_LOW_X) || (c == CHAR_UP_X);
    endfunction

    // Hex digit value of a byte, DIGIT_NONE when it is not a digit.
    function automatic logic [4:0] digit_of(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] t;
        t = {3'b000, DIGIT_NONE};
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            t = 8'(c - 8'h30);
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            t = 8'(c - 8'h57);
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            t = 8'(c - 8'h37);
        end
        return t[4:0];
    endfunction

    // One accumulation step, saturating at 2^31.
    function automatic logic [MAG_W-1:0] mag_step(input logic [MAG_W-1:0] mag,
                                                  input logic hex,
                                                  input logic [3:0] d);
        logic [STEP_W-1:0] w;
        if (hex)
        begin
            w = {mag, 4'b0000};
        end
        else
        begin
            w = {3'b000, mag, 1'b0} + {1'b0, mag, 3'b000};
        end
        w = w + {32'b0, d};
        if (w > {4'b0000, MAG_CAP})
        begin
            w = {4'b0000, MAG_CAP};
        end
        return w[MAG_W-1:0];
    endfunction

endpackage

>>> rtl/kvlp_ram.sv
module kvlp_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/kvlp_queue.sv
module kvlp_queue
#(
    parameter int WIDTH = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full       = count_reg[1];
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

endmodule

>>> rtl/kvlp_front.sv
module kvlp_front
#(
    parameter int LINE_CAPACITY = 128,
    parameter int NAME_LIMIT    = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic [kvlp_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 ram_wr_en,
    output logic [$clog2(NAME_LIMIT):0]          ram_wr_addr,
    output logic [kvlp_pkg::BYTE_W-1:0]          ram_wr_data,
    output logic                                 push,
    // Fields from the lowest bit: bank, name length, value.
    output logic [kvlp_pkg::VALUE_W+$clog2(NAME_LIMIT):0] push_data
);

    import kvlp_pkg::*;

    localparam int FILL_W  = $clog2(LINE_CAPACITY);
    localparam int NAME_AW = $clog2(NAME_LIMIT);
    localparam logic [FILL_W-1:0]  FILL_LAST = FILL_W'(LINE_CAPACITY - 1);
    localparam logic [NAME_AW-1:0] NAME_MAX  = NAME_AW'(NAME_LIMIT - 1);

    logic [FILL_W-1:0]  fill_reg,     fill_next;
    logic               ended_reg,    ended_next;
    logic               comma_reg,    comma_next;
    logic               too_long_reg, too_long_next;
    logic [NAME_AW-1:0] name_len_reg, name_len_next;
    scan_phase_t        phase_reg,    phase_next;
    logic               neg_reg,      neg_next;
    logic               xseen_reg,    xseen_next;
    logic               dec_live_reg, dec_live_next;
    logic [MAG_W-1:0]   dec_mag_reg,  dec_mag_next;
    hex_state_t         hex_reg,      hex_next;
    logic [MAG_W-1:0]   hex_mag_reg,  hex_mag_next;
    logic               bank_reg,     bank_next;

    logic               clear_line;
    logic               dig_step;
    logic [4:0]         digit;
    logic               is_hex_digit;
    logic [MAG_W-1:0]   final_mag;
    logic [VALUE_W-1:0] final_value;

    assign digit        = digit_of(rx_byte);
    assign is_hex_digit = (digit != DIGIT_NONE);

    // Value of the line so far: hex when an x appeared in the value text.
    always_comb
    begin
        final_mag = xseen_reg ? hex_mag_reg : dec_mag_reg;
        if (neg_reg)
        begin
            final_value = VALUE_W'(0) - final_mag;
        end
        else if (final_mag[MAG_W-1])
        begin
            final_value = VALUE_MAX;
        end
        else
        begin
            final_value = final_mag;
        end
    end

    // Byte classification and incremental scan of name and value.
    always_comb
    begin
        fill_next     = fill_reg;
        ended_next    = ended_reg;
        comma_next    = comma_reg;
        too_long_next = too_long_reg;
        name_len_next = name_len_reg;
        phase_next    = phase_reg;
        neg_next      = neg_reg;
        xseen_next    = xseen_reg;
        dec_live_next = dec_live_reg;
        dec_mag_next  = dec_mag_reg;
        hex_next      = hex_reg;
        hex_mag_next  = hex_mag_reg;
        bank_next     = bank_reg;
        clear_line    = 1'b0;
        dig_step      = 1'b0;
        ram_wr_en     = 1'b0;
        push          = 1'b0;

        if (accept)
        begin
            if (rx_byte == CHAR_NL)
            begin
                if (fill_reg != '0)
                begin
                    push       = comma_reg && (name_len_reg != '0) && !too_long_reg;
                    clear_line = 1'b1;
                end
            end
            else if (rx_byte == CHAR_CR)
            begin
                // Carriage return is skipped.
            end
            else if (fill_reg == FILL_LAST)
            begin
                // Store overflow drops the line.
                clear_line = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
                if (!ended_reg)
                begin
                    if (rx_byte == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (!comma_reg)
                    begin
                        if (rx_byte == CHAR_COMMA)
                        begin
                            comma_next = 1'b1;
                        end
                        else if (name_len_reg == NAME_MAX)
                        begin
                            too_long_next = 1'b1;
                        end
                        else
                        begin
                            ram_wr_en     = 1'b1;
                            name_len_next = name_len_reg + NAME_AW'(1);
                        end
                    end
                    else
                    begin
                        if (is_x(rx_byte))
                        begin
                            xseen_next = 1'b1;
                        end
                        if (phase_reg == PH_LEAD)
                        begin
                            if (is_space(rx_byte))
                            begin
                                phase_next = PH_LEAD;
                            end
                            else if ((rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS))
                            begin
                                neg_next   = (rx_byte == CHAR_MINUS);
                                phase_next = PH_DIGITS;
                            end
                            else
                            begin
                                phase_next = PH_DIGITS;
                                dig_step   = 1'b1;
                            end
                        end
                        else
                        begin
                            dig_step = 1'b1;
                        end
                    end
                end
            end
        end

        // Decimal and hex readings run side by side.
        if (dig_step)
        begin
            if (dec_live_reg)
            begin
                if (digit < DEC_BASE)
                begin
                    dec_mag_next = mag_step(dec_mag_reg, 1'b0, digit[3:0]);
                end
                else
                begin
                    dec_live_next = 1'b0;
                end
            end
            case (hex_reg)
                HX_FIRST:
                begin
                    if (rx_byte == CHAR_ZERO)
                    begin
                        hex_next = HX_ZERO;
                    end
                    else if (is_hex_digit)
                    begin
                        hex_mag_next = mag_step(hex_mag_reg, 1'b1, digit[3:0]);
                        hex_next     = HX_RUN;
                    end
                    else
                    begin
                        hex_next = HX_STOP;
                    end
                end
                HX_ZERO:
                begin
                    if (is_x(rx_byte))
                    begin
                        hex_next = HX_PREFIX;
                    end
                    else if (is_hex_digit)
                    begin
                        hex_mag_next = mag_step(hex_mag_reg, 1'b1, digit[3:0]);
                        hex_next     = HX_RUN;
                    end
                    else
                    begin
                        hex_next = HX_STOP;
                    end
                end
                HX_PREFIX, HX_RUN:
                begin
                    if (is_hex_digit)
                    begin
                        hex_mag_next = mag_step(hex_mag_reg, 1'b1, digit[3:0]);
                        hex_next     = HX_RUN;
                    end
                    else
                    begin
                        hex_next = HX_STOP;
                    end
                end
                default:
                begin
                    hex_next = HX_STOP;
                end
            endcase
        end

        if (push)
        begin
            bank_next = ~bank_reg;
        end

        // Start a fresh line.
        if (clear_line)
        begin
            fill_next     = '0;
            ended_next    = 1'b0;
            comma_next    = 1'b0;
            too_long_next = 1'b0;
            name_len_next = '0;
            phase_next    = PH_LEAD;
            neg_next      = 1'b0;
            xseen_next    = 1'b0;
            dec_live_next = 1'b1;
            dec_mag_next  = '0;
            hex_next      = HX_FIRST;
            hex_mag_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            ended_reg    <= 1'b0;
            comma_reg    <= 1'b0;
            too_long_reg <= 1'b0;
            name_len_reg <= '0;
            phase_reg    <= PH_LEAD;
            neg_reg      <= 1'b0;
            xseen_reg    <= 1'b0;
            dec_live_reg <= 1'b1;
            dec_mag_reg  <= '0;
            hex_reg      <= HX_FIRST;
            hex_mag_reg  <= '0;
            bank_reg     <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            ended_reg    <= ended_next;
            comma_reg    <= comma_next;
            too_long_reg <= too_long_next;
            name_len_reg <= name_len_next;
            phase_reg    <= phase_next;
            neg_reg      <= neg_next;
            xseen_reg    <= xseen_next;
            dec_live_reg <= dec_live_next;
            dec_mag_reg  <= dec_mag_next;
            hex_reg      <= hex_next;
            hex_mag_reg  <= hex_mag_next;
            bank_reg     <= bank_next;
        end
    end

    assign ram_wr_addr = {bank_reg, name_len_reg};
    assign ram_wr_data = rx_byte;
    assign push_data   = {final_value, name_len_reg, bank_reg};

endmodule

>>> rtl/kvlp_back.sv
module kvlp_back
#(
    parameter int NAME_LIMIT = 64
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          head_valid,
    // Fields from the lowest bit: bank, name length, value.
    input  logic [kvlp_pkg::VALUE_W+$clog2(NAME_LIMIT):0] head_data,
    output logic                                          pop,
    output logic                                          ram_rd_en,
    output logic [$clog2(NAME_LIMIT):0]                   ram_rd_addr,
    input  logic [kvlp_pkg::BYTE_W-1:0]                   ram_rd_data,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // Fields from the lowest bit: name_byte, signal_value.
    output logic [kvlp_pkg::BYTE_W+kvlp_pkg::VALUE_W-1:0] m_tdata,
    output logic                                          m_tlast
);

    import kvlp_pkg::*;

    localparam int NAME_AW = $clog2(NAME_LIMIT);

    back_state_t        state_reg, state_next;
    logic [NAME_AW-1:0] pos_reg,   pos_next;
    logic [BYTE_W-1:0]  byte_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic               load;

    logic               head_bank;
    logic [NAME_AW-1:0] head_len;
    logic [VALUE_W-1:0] head_value;

    assign head_bank  = head_data[0];
    assign head_len   = head_data[NAME_AW:1];
    assign head_value = head_data[VALUE_W+NAME_AW:NAME_AW+1];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                state_next = BK_SEND;
            end
            BK_SEND:
            begin
                if (m_tready)
                begin
                    state_next = last_reg ? BK_IDLE : BK_WAIT;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Read requests, word loading and queue release.
    always_comb
    begin
        ram_rd_en = 1'b0;
        pos_next  = pos_reg;
        load      = 1'b0;
        pop       = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pos_next  = '0;
                ram_rd_en = head_valid;
            end
            BK_WAIT:
            begin
                load = 1'b1;
            end
            BK_SEND:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        pop = 1'b1;
                    end
                    else
                    begin
                        pos_next  = pos_reg + NAME_AW'(1);
                        ram_rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                pos_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= ram_rd_data;
            value_reg <= head_value;
            last_reg  <= (pos_reg == NAME_AW'(head_len - NAME_AW'(1)));
        end
    end

    assign ram_rd_addr = {head_bank, pos_next};
    assign m_tvalid    = (state_reg == BK_SEND);
    assign m_tdata     = {value_reg, byte_reg};
    assign m_tlast     = last_reg;

endmodule

>>> rtl/key_value_line_parser.sv
// Key/value line parser.
// The slave channel takes one received character per word in s_tdata.
// Lines of the form NAME,VALUE end with a newline; carriage returns are
// skipped. For each valid line the master channel gives one word per name
// character: the character and the parsed, saturated 32-bit value in
// m_tdata, with m_tlast high on the final character of the name.
// The front scans each character as it arrives, so a line is fully
// parsed when its newline is taken, at one character per cycle while
// s_tready is high. Name characters sit in a two-bank buffer RAM;
// finished lines wait in a two-entry queue. Each output word is preceded
// by its own registered RAM read, issued once the previous word is taken,
// and the first word of a line follows its newline through the queue.
// s_tready drops while two lines are waiting or being sent, which happens
// when the master side stalls or when short lines follow a long name.
// Reset clears the line state and the queue; no word is pending after it.
// A stall on m_tready holds the current word until it is taken.
module key_value_line_parser
#(
    parameter int LINE_CAPACITY = 128,
    parameter int NAME_LIMIT    = 64
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // Fields from the lowest bit: rx_byte.
    input  logic [kvlp_pkg::BYTE_W-1:0]                   s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // Fields from the lowest bit: name_byte, signal_value.
    output logic [kvlp_pkg::BYTE_W+kvlp_pkg::VALUE_W-1:0] m_tdata,
    output logic                                          m_tlast
);

    import kvlp_pkg::*;

    localparam int NAME_AW = $clog2(NAME_LIMIT);
    localparam int DESC_W  = VALUE_W + NAME_AW + 1;

    logic               accept;
    logic               queue_full;
    logic               ram_wr_en;
    logic [NAME_AW:0]   ram_wr_addr;
    logic [BYTE_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [NAME_AW:0]   ram_rd_addr;
    logic [BYTE_W-1:0]  ram_rd_data;
    logic               push;
    logic [DESC_W-1:0]  push_data;
    logic               pop;
    logic               head_valid;
    logic [DESC_W-1:0]  head_data;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    kvlp_front
    #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .NAME_LIMIT    (NAME_LIMIT)
    )
    u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .push        (push),
        .push_data   (push_data)
    );

    kvlp_ram
    #(
        .WIDTH (BYTE_W),
        .DEPTH (2 ** (NAME_AW + 1))
    )
    u_name_ram
    (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    kvlp_queue
    #(
        .WIDTH (DESC_W)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    kvlp_back
    #(
        .NAME_LIMIT (NAME_LIMIT)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
